>>> sv/assert_macros.svh
// Assertion helpers; clk and rst_n are taken from the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CDIT_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("same-cycle check failed");
`define CDIT_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define CDIT_ASSERT_IMP(lbl, a, b)
`define CDIT_ASSERT_NXT(lbl, a, b)
`endif
`endif

>>> sv/cdit_pkg.sv
package cdit_pkg;

  localparam logic [1:0] OP_ISSUE     = 2'd0;
  localparam logic [1:0] OP_IRQ       = 2'd1;
  localparam logic [1:0] OP_SYNC      = 2'd2;
  localparam logic [1:0] OP_CLR_MEDIA = 2'd3;

  localparam logic [2:0] IRQ_NONE     = 3'd0;
  localparam logic [2:0] IRQ_READY    = 3'd1;
  localparam logic [2:0] IRQ_COMPLETE = 3'd2;
  localparam logic [2:0] IRQ_ACK      = 3'd3;
  localparam logic [2:0] IRQ_END      = 3'd4;
  localparam logic [2:0] IRQ_ERROR    = 3'd5;

  localparam logic [2:0] HND_NONE     = 3'd0;
  localparam logic [2:0] HND_READY    = 3'd1;
  localparam logic [2:0] HND_OVERRIDE = 3'd2;
  localparam logic [2:0] HND_COMPLETE = 3'd3;
  localparam logic [2:0] HND_PAUSE    = 3'd4;

  localparam logic [1:0] CFG_READY    = 2'd0;
  localparam logic [1:0] CFG_COMPLETE = 2'd1;
  localparam logic [1:0] CFG_PAUSE    = 2'd2;
  localparam logic [1:0] CFG_OVERRIDE = 2'd3;

  localparam logic [7:0] CMD_SETMODE = 8'd14;
  localparam int unsigned SHELL_OPEN_BIT = 4;

  localparam logic [7:0] FL_STATUS   = 8'h04;
  localparam logic [7:0] FL_CSTATUS  = 8'h08;
  localparam logic [7:0] FL_BLOCKING = 8'h10;
  localparam logic [7:0] FL_OPTIONAL = 8'h20;
  localparam logic [7:0] FL_SETLOC   = 8'h40;

  typedef struct packed {
    logic       rejected;
    logic       send_seek_first;
    logic [1:0] param_count;
    logic [2:0] handler_select;
    logic       error_notify_completion;
    logic [7:0] drive_status;
    logic [7:0] drive_error;
    logic       media_changed;
    logic [2:0] sync_result;
    logic       ack_waiting;
    logic       completion_waiting;
    logic [7:0] mode_setting;
  } res_t;

  typedef struct packed {
    logic push;
    logic pop;
  } buf_ctl_t;

  function automatic logic [7:0] cmd_flags(input logic [7:0] cmd);
    logic [7:0] f;
    case (cmd)
      8'd0:  f = 8'h00;
      8'd1:  f = FL_STATUS;
      8'd2:  f = FL_STATUS | 8'd3;
      8'd3:  f = FL_STATUS | FL_OPTIONAL | 8'd1;
      8'd4:  f = FL_STATUS;
      8'd5:  f = FL_STATUS;
      8'd6:  f = FL_STATUS | FL_SETLOC;
      8'd7:  f = FL_STATUS | FL_CSTATUS | FL_BLOCKING;
      8'd8:  f = FL_STATUS | FL_CSTATUS | FL_BLOCKING;
      8'd9:  f = FL_STATUS | FL_CSTATUS | FL_BLOCKING;
      8'd10: f = FL_STATUS | FL_CSTATUS | FL_BLOCKING;
      8'd11: f = FL_STATUS;
      8'd12: f = FL_STATUS;
      8'd13: f = FL_STATUS | 8'd2;
      8'd14: f = FL_STATUS | 8'd1;
      8'd15: f = FL_STATUS;
      8'd16: f = 8'h00;
      8'd17: f = 8'h00;
      8'd18: f = FL_STATUS | FL_CSTATUS | FL_BLOCKING | 8'd1;
      8'd19: f = FL_STATUS;
      8'd20: f = FL_STATUS | 8'd1;
      8'd21: f = FL_STATUS | FL_CSTATUS | FL_BLOCKING | FL_SETLOC;
      8'd22: f = FL_STATUS | FL_CSTATUS | FL_BLOCKING | FL_SETLOC;
      8'd23: f = 8'h00;
      8'd24: f = 8'h00;
      8'd25: f = 8'd1;
      8'd26: f = FL_STATUS | FL_CSTATUS | FL_BLOCKING;
      8'd27: f = FL_STATUS | FL_SETLOC;
      8'd28: f = FL_STATUS;
      8'd29: f = FL_STATUS | FL_BLOCKING | 8'd2;
      8'd30: f = FL_STATUS | FL_CSTATUS | FL_BLOCKING;
      default: f = 8'h00;
    endcase
    return f;
  endfunction

endpackage

>>> sv/cdit_out_buf.sv
`include "assert_macros.svh"

module cdit_out_buf
  import cdit_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  buf_ctl_t ctl,
  input  res_t     din,
  output logic     full,
  output logic     out_valid,
  output res_t     dout
);

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_data_r, out_data_nxt;
  res_t skid_data_r, skid_data_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (ctl.pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (ctl.push) begin
      if (!out_valid_r || ctl.pop) begin
        out_data_nxt  = din;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = din;
        skid_valid_nxt = 1'b1;
      end
    end else if (ctl.pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign dout      = out_data_r;

  `CDIT_ASSERT_IMP(a_skid_needs_out, skid_valid_r, out_valid_r)
  `CDIT_ASSERT_NXT(a_skid_holds, skid_valid_r && !ctl.pop, skid_valid_r && out_valid_r)
  `CDIT_ASSERT_NXT(a_push_full_to_skid, ctl.push && out_valid_r && !ctl.pop && !skid_valid_r,
                   skid_valid_r && $stable(out_data_r))
  `CDIT_ASSERT_IMP(a_no_push_when_full, skid_valid_r, !ctl.push)

endmodule

>>> sv/cd_command_interrupt_tracker.sv
// Channel | Handshake            | Payload
// in_     | in_valid / in_stall  | op, command, param_given, mode_byte, irq_*
// out_    | out_valid / out_stall| rejected .. mode_setting, one item per input
// cfg_    | cfg_valid / cfg_ready| cfg_index (2b), cfg_data (1b), ready always high
// One item per cycle while in_stall is low.
// Tracker state and the output stage (result register or skid) update in the accepting cycle.
// A two-entry output stage (result register plus skid) keeps input open
// while one result waits; in_stall rises only when both entries are full.
// rst_n is synchronous, active low; no clearing pass is needed.

module cd_command_interrupt_tracker
  import cdit_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_op,
  input  logic [7:0] in_command,
  input  logic       in_param_given,
  input  logic [7:0] in_mode_byte,
  input  logic [2:0] in_irq_code,
  input  logic [7:0] in_irq_first_byte,
  input  logic [7:0] in_irq_error_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_rejected,
  output logic       out_send_seek_first,
  output logic [1:0] out_param_count,
  output logic [2:0] out_handler_select,
  output logic       out_error_notify_completion,
  output logic [7:0] out_drive_status,
  output logic [7:0] out_drive_error,
  output logic       out_media_changed,
  output logic [2:0] out_sync_result,
  output logic       out_ack_waiting,
  output logic       out_completion_waiting,
  output logic [7:0] out_mode_setting,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic       cfg_data
);

  logic ready_hnd_r, comp_hnd_r, pause_hnd_r, ovr_hnd_r;

  logic [7:0] cur_cmd_r, cur_cmd_nxt;
  logic       ack_r, ack_nxt;
  logic       comp_r, comp_nxt;
  logic [7:0] status_r, status_nxt;
  logic [7:0] error_r, error_nxt;
  logic [2:0] prev_irq_r, prev_irq_nxt;
  logic [7:0] mode_r, mode_nxt;
  logic       shell_r, shell_nxt;

  logic       accept;
  logic       buf_full;
  buf_ctl_t   ctl;
  res_t       res, res_q;
  logic [7:0] f_in, f_cur;
  logic       take;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign accept    = in_valid && !buf_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_hnd_r <= 1'b0;
      comp_hnd_r  <= 1'b0;
      pause_hnd_r <= 1'b0;
      ovr_hnd_r   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_READY:    ready_hnd_r <= cfg_data;
        CFG_COMPLETE: comp_hnd_r  <= cfg_data;
        CFG_PAUSE:    pause_hnd_r <= cfg_data;
        CFG_OVERRIDE: ovr_hnd_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign f_in  = cmd_flags(in_command);
  assign f_cur = cmd_flags(cur_cmd_r);

  always_comb begin
    cur_cmd_nxt  = cur_cmd_r;
    ack_nxt      = ack_r;
    comp_nxt     = comp_r;
    status_nxt   = status_r;
    error_nxt    = error_r;
    prev_irq_nxt = prev_irq_r;
    mode_nxt     = mode_r;
    shell_nxt    = shell_r;
    take         = 1'b0;
    res          = '0;
    case (in_op)
      OP_ISSUE: begin
        if ((f_in & FL_OPTIONAL) != 8'h00) begin
          res.param_count = in_param_given ? f_in[1:0] : 2'd0;
        end else if ((f_in & FL_SETLOC) != 8'h00) begin
          res.send_seek_first = in_param_given;
        end else if (f_in[1:0] != 2'd0 && !in_param_given) begin
          res.rejected = 1'b1;
        end else begin
          res.param_count = f_in[1:0];
        end
        if (!res.rejected) begin
          cur_cmd_nxt = in_command;
          ack_nxt     = 1'b1;
          if ((f_in & FL_BLOCKING) != 8'h00) comp_nxt = 1'b1;
          if (in_command == CMD_SETMODE) mode_nxt = in_mode_byte;
        end
      end
      OP_IRQ: begin
        if (in_irq_code >= IRQ_READY && in_irq_code <= IRQ_ERROR) begin
          case (in_irq_code)
            IRQ_READY: begin
              res.handler_select = ovr_hnd_r ? HND_OVERRIDE :
                                   (ready_hnd_r ? HND_READY : HND_NONE);
              take = 1'b1;
            end
            IRQ_COMPLETE: begin
              comp_nxt = 1'b0;
              res.handler_select = comp_hnd_r ? HND_COMPLETE : HND_NONE;
              take = (f_cur & FL_CSTATUS) != 8'h00;
            end
            IRQ_ACK: begin
              ack_nxt = 1'b0;
              take = (f_cur & FL_STATUS) != 8'h00;
            end
            IRQ_END: begin
              res.handler_select = pause_hnd_r ? HND_PAUSE : HND_NONE;
              take = 1'b1;
            end
            default: begin
              error_nxt = in_irq_error_byte;
              res.handler_select = ready_hnd_r ? HND_READY : HND_NONE;
              if (ack_r || comp_r) begin
                res.error_notify_completion = comp_hnd_r;
                ack_nxt  = 1'b0;
                comp_nxt = 1'b0;
              end
              take = 1'b1;
            end
          endcase
          cur_cmd_nxt  = 8'd0;
          prev_irq_nxt = in_irq_code;
        end
      end
      OP_CLR_MEDIA: shell_nxt = 1'b0;
      default: ;
    endcase
    if (take) begin
      if (!status_r[SHELL_OPEN_BIT] && in_irq_first_byte[SHELL_OPEN_BIT]) shell_nxt = 1'b1;
      status_nxt = in_irq_first_byte;
    end
    res.drive_status       = status_nxt;
    res.drive_error        = error_nxt;
    res.media_changed      = shell_nxt;
    res.sync_result        = comp_nxt ? IRQ_NONE :
                             (prev_irq_nxt == IRQ_ACK ? IRQ_COMPLETE : prev_irq_nxt);
    res.ack_waiting        = ack_nxt;
    res.completion_waiting = comp_nxt;
    res.mode_setting       = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_cmd_r  <= 8'd0;
      ack_r      <= 1'b0;
      comp_r     <= 1'b0;
      status_r   <= 8'd0;
      error_r    <= 8'd0;
      prev_irq_r <= IRQ_NONE;
      mode_r     <= 8'd0;
      shell_r    <= 1'b1;
    end else if (accept) begin
      cur_cmd_r  <= cur_cmd_nxt;
      ack_r      <= ack_nxt;
      comp_r     <= comp_nxt;
      status_r   <= status_nxt;
      error_r    <= error_nxt;
      prev_irq_r <= prev_irq_nxt;
      mode_r     <= mode_nxt;
      shell_r    <= shell_nxt;
    end
  end

  assign ctl.push = accept;
  assign ctl.pop  = out_valid && !out_stall;

  cdit_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .din       (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .dout      (res_q)
  );

  assign out_rejected                = res_q.rejected;
  assign out_send_seek_first         = res_q.send_seek_first;
  assign out_param_count             = res_q.param_count;
  assign out_handler_select          = res_q.handler_select;
  assign out_error_notify_completion = res_q.error_notify_completion;
  assign out_drive_status            = res_q.drive_status;
  assign out_drive_error             = res_q.drive_error;
  assign out_media_changed           = res_q.media_changed;
  assign out_sync_result             = res_q.sync_result;
  assign out_ack_waiting             = res_q.ack_waiting;
  assign out_completion_waiting      = res_q.completion_waiting;
  assign out_mode_setting            = res_q.mode_setting;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cdit_pkg::*;

  localparam int IDLE_LIMIT = 3000;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] command;
    logic       param_given;
    logic [7:0] mode_byte;
    logic [2:0] irq_code;
    logic [7:0] status_in;
    logic [7:0] error_byte;
  } cd_item_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_op;
  logic [7:0] in_command;
  logic       in_param_given;
  logic [7:0] in_mode_byte;
  logic [2:0] in_irq_code;
  logic [7:0] in_irq_first_byte;
  logic [7:0] in_irq_error_byte;
  logic       out_valid;
  logic       out_stall;
  logic       out_rejected;
  logic       out_send_seek_first;
  logic [1:0] out_param_count;
  logic [2:0] out_handler_select;
  logic       out_error_notify_completion;
  logic [7:0] out_drive_status;
  logic [7:0] out_drive_error;
  logic       out_media_changed;
  logic [2:0] out_sync_result;
  logic       out_ack_waiting;
  logic       out_completion_waiting;
  logic [7:0] out_mode_setting;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic       cfg_data;

  cd_command_interrupt_tracker DUT (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .in_valid                   (in_valid),
    .in_stall                   (in_stall),
    .in_op                      (in_op),
    .in_command                 (in_command),
    .in_param_given             (in_param_given),
    .in_mode_byte               (in_mode_byte),
    .in_irq_code                (in_irq_code),
    .in_irq_first_byte          (in_irq_first_byte),
    .in_irq_error_byte          (in_irq_error_byte),
    .out_valid                  (out_valid),
    .out_stall                  (out_stall),
    .out_rejected               (out_rejected),
    .out_send_seek_first        (out_send_seek_first),
    .out_param_count            (out_param_count),
    .out_handler_select         (out_handler_select),
    .out_error_notify_completion(out_error_notify_completion),
    .out_drive_status           (out_drive_status),
    .out_drive_error            (out_drive_error),
    .out_media_changed          (out_media_changed),
    .out_sync_result            (out_sync_result),
    .out_ack_waiting            (out_ack_waiting),
    .out_completion_waiting     (out_completion_waiting),
    .out_mode_setting           (out_mode_setting),
    .cfg_valid                  (cfg_valid),
    .cfg_ready                  (cfg_ready),
    .cfg_index                  (cfg_index),
    .cfg_data                   (cfg_data)
  );

  // tracker copy
  logic [7:0] trk_cmd;
  logic       trk_ack;
  logic       trk_cmpl;
  logic [7:0] trk_status;
  logic [7:0] trk_error;
  logic [2:0] trk_prev_irq;
  logic [7:0] trk_mode;
  logic       trk_shell;
  logic       hnd_ready_on;
  logic       hnd_cmpl_on;
  logic       hnd_pause_on;
  logic       hnd_over_on;

  res_t expected_results[$];
  int   errors;
  int   idle_cycles;
  int   calm_left;

  always #5 clk = ~clk;

  function automatic logic [7:0] cmd_attr(input logic [7:0] cmd);
    case (cmd)
      8'd1, 8'd4, 8'd5, 8'd11, 8'd12, 8'd15, 8'd19, 8'd28: return FL_STATUS;
      8'd2:                                 return FL_STATUS | 8'd3;
      8'd3:                                 return FL_STATUS | FL_OPTIONAL | 8'd1;
      8'd6, 8'd27:                          return FL_STATUS | FL_SETLOC;
      8'd7, 8'd8, 8'd9, 8'd10, 8'd26, 8'd30: return FL_STATUS | FL_CSTATUS | FL_BLOCKING;
      8'd13:                                return FL_STATUS | 8'd2;
      8'd14, 8'd20:                         return FL_STATUS | 8'd1;
      8'd18:                                return FL_STATUS | FL_CSTATUS | FL_BLOCKING | 8'd1;
      8'd21, 8'd22:   return FL_STATUS | FL_CSTATUS | FL_BLOCKING | FL_SETLOC;
      8'd25:                                return 8'd1;
      8'd29:                                return FL_STATUS | FL_BLOCKING | 8'd2;
      default:                              return 8'd0;
    endcase
  endfunction

  function automatic void latch_status(input logic [7:0] s);
    if (!trk_status[SHELL_OPEN_BIT] && s[SHELL_OPEN_BIT]) trk_shell = 1'b1;
    trk_status = s;
  endfunction

  function automatic res_t track_item(input cd_item_t it);
    res_t       r;
    logic [7:0] f;
    logic       ok;
    r = '0;
    case (it.op)
      OP_ISSUE: begin
        f = cmd_attr(it.command);
        ok = 1'b1;
        if ((f & FL_OPTIONAL) != 0) begin
          r.param_count = it.param_given ? f[1:0] : 2'd0;
        end else if ((f & FL_SETLOC) != 0) begin
          r.send_seek_first = it.param_given;
        end else begin
          r.param_count = f[1:0];
          if (f[1:0] != 2'd0 && !it.param_given) begin
            ok = 1'b0;
            r.rejected = 1'b1;
            r.param_count = 2'd0;
          end
        end
        if (ok) begin
          trk_cmd = it.command;
          trk_ack = 1'b1;
          if ((f & FL_BLOCKING) != 0) trk_cmpl = 1'b1;
          if (it.command == CMD_SETMODE) trk_mode = it.mode_byte;
        end
      end
      OP_IRQ: begin
        if (it.irq_code >= IRQ_READY && it.irq_code <= IRQ_ERROR) begin
          f = cmd_attr(trk_cmd);
          case (it.irq_code)
            IRQ_READY: begin
              r.handler_select = hnd_over_on ? HND_OVERRIDE :
                                 (hnd_ready_on ? HND_READY : HND_NONE);
              latch_status(it.status_in);
            end
            IRQ_COMPLETE: begin
              trk_cmpl = 1'b0;
              r.handler_select = hnd_cmpl_on ? HND_COMPLETE : HND_NONE;
              if ((f & FL_CSTATUS) != 0) latch_status(it.status_in);
            end
            IRQ_ACK: begin
              trk_ack = 1'b0;
              if ((f & FL_STATUS) != 0) latch_status(it.status_in);
            end
            IRQ_END: begin
              r.handler_select = hnd_pause_on ? HND_PAUSE : HND_NONE;
              latch_status(it.status_in);
            end
            default: begin
              trk_error = it.error_byte;
              r.handler_select = hnd_ready_on ? HND_READY : HND_NONE;
              if (trk_ack || trk_cmpl) begin
                r.error_notify_completion = hnd_cmpl_on;
                trk_ack = 1'b0;
                trk_cmpl = 1'b0;
              end
              latch_status(it.status_in);
            end
          endcase
          trk_cmd = 8'd0;
          trk_prev_irq = it.irq_code;
        end
      end
      OP_CLR_MEDIA: trk_shell = 1'b0;
      default: ;
    endcase
    r.drive_status = trk_status;
    r.drive_error = trk_error;
    r.media_changed = trk_shell;
    r.sync_result = trk_cmpl ? IRQ_NONE :
                    ((trk_prev_irq == IRQ_ACK) ? IRQ_COMPLETE : trk_prev_irq);
    r.ack_waiting = trk_ack;
    r.completion_waiting = trk_cmpl;
    r.mode_setting = trk_mode;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // scoreboard: check results, then record the item taken at this edge
  always @(posedge clk) begin
    res_t     exp_r;
    cd_item_t it;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_READY:    hnd_ready_on = cfg_data;
          CFG_COMPLETE: hnd_cmpl_on = cfg_data;
          CFG_PAUSE:    hnd_pause_on = cfg_data;
          CFG_OVERRIDE: hnd_over_on = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding");
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("rejected", 32'(exp_r.rejected), 32'(out_rejected));
          check_field("send_seek_first", 32'(exp_r.send_seek_first),
                      32'(out_send_seek_first));
          check_field("param_count", 32'(exp_r.param_count), 32'(out_param_count));
          check_field("handler_select", 32'(exp_r.handler_select),
                      32'(out_handler_select));
          check_field("error_notify_completion", 32'(exp_r.error_notify_completion),
                      32'(out_error_notify_completion));
          check_field("drive_status", 32'(exp_r.drive_status), 32'(out_drive_status));
          check_field("drive_error", 32'(exp_r.drive_error), 32'(out_drive_error));
          check_field("media_changed", 32'(exp_r.media_changed), 32'(out_media_changed));
          check_field("sync_result", 32'(exp_r.sync_result), 32'(out_sync_result));
          check_field("ack_waiting", 32'(exp_r.ack_waiting), 32'(out_ack_waiting));
          check_field("completion_waiting", 32'(exp_r.completion_waiting),
                      32'(out_completion_waiting));
          check_field("mode_setting", 32'(exp_r.mode_setting), 32'(out_mode_setting));
        end
      end
      if (in_valid && !in_stall) begin
        it.op = in_op;
        it.command = in_command;
        it.param_given = in_param_given;
        it.mode_byte = in_mode_byte;
        it.irq_code = in_irq_code;
        it.status_in = in_irq_first_byte;
        it.error_byte = in_irq_error_byte;
        expected_results.push_back(track_item(it));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver backpressure
  always begin
    int run;
    int gap;
    run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
    repeat (run) @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      out_stall <= 1'b1;
      repeat (gap) @(negedge clk);
      out_stall <= 1'b0;
    end
  end

  function automatic cd_item_t mk_item(input logic [1:0] op, input logic [7:0] cmd,
                                       input logic param, input logic [7:0] mode,
                                       input logic [2:0] irq, input logic [7:0] first,
                                       input logic [7:0] errb);
    cd_item_t it;
    it.op = op;
    it.command = cmd;
    it.param_given = param;
    it.mode_byte = mode;
    it.irq_code = irq;
    it.status_in = first;
    it.error_byte = errb;
    return it;
  endfunction

  function automatic cd_item_t rand_item();
    return mk_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
  endfunction

  function automatic cd_item_t irq_item(input logic [2:0] code);
    cd_item_t it;
    it = rand_item();
    it.op = OP_IRQ;
    it.irq_code = code;
    return it;
  endfunction

  function automatic cd_item_t op_item(input logic [1:0] op);
    cd_item_t it;
    it = rand_item();
    it.op = op;
    return it;
  endfunction

  task automatic send_item(input cd_item_t it);
    int gap;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(10, 40);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op <= it.op;
    in_command <= it.command;
    in_param_given <= it.param_given;
    in_mode_byte <= it.mode_byte;
    in_irq_code <= it.irq_code;
    in_irq_first_byte <= it.status_in;
    in_irq_error_byte <= it.error_byte;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic sender_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic value);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_handlers(input logic [3:0] s);
    sender_idle();
    wait_drained();
    write_cfg(CFG_READY, s[0]);
    write_cfg(CFG_COMPLETE, s[1]);
    write_cfg(CFG_PAUSE, s[2]);
    write_cfg(CFG_OVERRIDE, s[3]);
  endtask

  task automatic run_traffic(input int n);
    int         sent;
    int         k;
    cd_item_t   it;
    logic [7:0] f;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) == 0) begin
        sender_idle();
        wait_drained();
      end
      if ($urandom_range(0, 99) < 70) begin
        it = op_item(OP_ISSUE);
        if ($urandom_range(0, 15) == 0) it.command = 8'($urandom_range(31, 255));
        else it.command = 8'($urandom_range(0, 30));
        if ($urandom_range(0, 3) == 0) it.command = CMD_SETMODE;
        it.param_given = ($urandom_range(0, 9) != 0);
        send_item(it);
        sent++;
        f = cmd_attr(it.command);
        k = $urandom_range(0, 2);
        repeat (k) begin
          send_item(irq_item($urandom_range(0, 1) ? IRQ_READY : IRQ_END));
          sent++;
        end
        send_item(irq_item(($urandom_range(0, 9) != 0) ? IRQ_ACK : IRQ_ERROR));
        sent++;
        if ((f & FL_BLOCKING) != 0) begin
          k = $urandom_range(0, 3);
          repeat (k) begin
            send_item(irq_item(IRQ_READY));
            sent++;
          end
          if ($urandom_range(0, 2) == 0) begin
            send_item(op_item(OP_SYNC));
            sent++;
          end
          send_item(irq_item(($urandom_range(0, 6) != 0) ? IRQ_COMPLETE : IRQ_ERROR));
          sent++;
        end
        if ($urandom_range(0, 7) == 0) begin
          send_item(op_item(OP_SYNC));
          sent++;
        end
        if ($urandom_range(0, 11) == 0) begin
          send_item(op_item(OP_CLR_MEDIA));
          sent++;
        end
      end else begin
        send_item(rand_item());
        sent++;
      end
    end
  endtask

  task automatic test_reset_state();
    send_item(mk_item(OP_SYNC, 8'd0, 1'b0, 8'd0, IRQ_NONE, 8'd0, 8'd0));
  endtask

  task automatic test_directed_ops();
    apply_handlers(4'b1111);
    send_item(mk_item(OP_CLR_MEDIA, 8'd0, 1'b0, 8'd0, IRQ_NONE, 8'd0, 8'd0));
    send_item(mk_item(OP_ISSUE, 8'd2, 1'b0, 8'd0, IRQ_NONE, 8'd0, 8'd0));
    send_item(mk_item(OP_ISSUE, 8'd2, 1'b1, 8'd0, IRQ_NONE, 8'd0, 8'd0));
    send_item(mk_item(OP_ISSUE, 8'd3, 1'b0, 8'd0, IRQ_NONE, 8'd0, 8'd0));
    send_item(mk_item(OP_ISSUE, 8'd3, 1'b1, 8'd0, IRQ_NONE, 8'd0, 8'd0));
    send_item(mk_item(OP_ISSUE, 8'd6, 1'b1, 8'd0, IRQ_NONE, 8'd0, 8'd0));
    send_item(mk_item(OP_ISSUE, CMD_SETMODE, 1'b1, 8'hFF, IRQ_NONE, 8'd0, 8'd0));
    send_item(mk_item(OP_IRQ, 8'd0, 1'b0, 8'd0, IRQ_ACK, 8'h10, 8'd0));
    send_item(mk_item(OP_ISSUE, 8'd7, 1'b0, 8'd0, IRQ_NONE, 8'd0, 8'd0));
    send_item(mk_item(OP_IRQ, 8'd0, 1'b0, 8'd0, IRQ_ACK, 8'hEF, 8'd0));
    send_item(mk_item(OP_SYNC, 8'hFF, 1'b1, 8'hFF, IRQ_NONE, 8'hFF, 8'hFF));
    send_item(mk_item(OP_IRQ, 8'd0, 1'b0, 8'd0, IRQ_COMPLETE, 8'hFF, 8'd0));
    send_item(mk_item(OP_IRQ, 8'd0, 1'b0, 8'd0, IRQ_READY, 8'h00, 8'd0));
    send_item(mk_item(OP_IRQ, 8'd0, 1'b0, 8'd0, IRQ_END, 8'hFF, 8'd0));
    send_item(mk_item(OP_ISSUE, 8'd255, 1'b0, 8'd0, IRQ_NONE, 8'd0, 8'd0));
    send_item(mk_item(OP_ISSUE, 8'd31, 1'b1, 8'd0, IRQ_NONE, 8'd0, 8'd0));
    send_item(mk_item(OP_ISSUE, 8'd30, 1'b0, 8'd0, IRQ_NONE, 8'd0, 8'd0));
    send_item(mk_item(OP_IRQ, 8'd0, 1'b0, 8'd0, IRQ_ERROR, 8'h00, 8'hFF));
    send_item(mk_item(OP_IRQ, 8'd0, 1'b0, 8'd0, IRQ_ERROR, 8'h10, 8'h00));
    send_item(mk_item(OP_IRQ, 8'd0, 1'b0, 8'd0, IRQ_NONE, 8'hFF, 8'hFF));
    send_item(mk_item(OP_IRQ, 8'd0, 1'b0, 8'd0, 3'd6, 8'hFF, 8'hFF));
    send_item(mk_item(OP_IRQ, 8'd0, 1'b0, 8'd0, 3'd7, 8'hFF, 8'hFF));
    send_item(mk_item(OP_ISSUE, CMD_SETMODE, 1'b1, 8'h00, IRQ_NONE, 8'd0, 8'd0));
    send_item(mk_item(OP_ISSUE, 8'd25, 1'b0, 8'd0, IRQ_NONE, 8'd0, 8'd0));
  endtask

  task automatic test_handler_settings();
    int         k;
    logic [3:0] s;
    for (k = 0; k < 7; k++) begin
      case (k)
        0: s = 4'b0000;
        1: s = 4'b1111;
        2: s = 4'b0111;
        3: s = 4'b1010;
        4: s = 4'b0101;
        default: s = 4'($urandom_range(0, 15));
      endcase
      apply_handlers(s);
      run_traffic(150);
    end
  endtask

  task automatic test_drain_pause();
    run_traffic(60);
    sender_idle();
    wait_drained();
    run_traffic(60);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_SYNC;
    in_command = 8'd0;
    in_param_given = 1'b0;
    in_mode_byte = 8'd0;
    in_irq_code = IRQ_NONE;
    in_irq_first_byte = 8'd0;
    in_irq_error_byte = 8'd0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_READY;
    cfg_data = 1'b0;
    errors = 0;
    idle_cycles = 0;
    calm_left = 0;
    trk_cmd = 8'd0;
    trk_ack = 1'b0;
    trk_cmpl = 1'b0;
    trk_status = 8'd0;
    trk_error = 8'd0;
    trk_prev_irq = IRQ_NONE;
    trk_mode = 8'd0;
    trk_shell = 1'b1;
    hnd_ready_on = 1'b0;
    hnd_cmpl_on = 1'b0;
    hnd_pause_on = 1'b0;
    hnd_over_on = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_directed_ops();
    test_handler_settings();
    test_drain_pause();
    sender_idle();
    wait_drained();
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
